FILE: sv/lnde_pkg.sv
// ----------------------------------------------------------------------------
// lnde_pkg
// Types and constants shared by the line-number delta encoder modules.
// ----------------------------------------------------------------------------
package lnde_pkg;

  localparam int PC_W       = 16;
  localparam int LINE_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int MAX_BYTES  = 5;
  localparam int BIDX_W     = 3;   // index of a byte within one encoded entry
  localparam int DELTA_W    = 17;  // 16-bit difference plus sign
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LINE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_BIG_ENDIAN = 2'd2;

  // Format tags
  localparam logic [1:0]        TAG_TWO_BYTE   = 2'b10;
  localparam logic [2:0]        TAG_THREE_BYTE = 3'b110;
  localparam logic [BYTE_W-1:0] TAG_FIVE_POS   = 8'hE0;
  localparam logic [BYTE_W-1:0] TAG_FIVE_NEG   = 8'hE1;

  typedef struct packed {
    logic [PC_W-1:0]   initial_pc;
    logic [LINE_W-1:0] initial_line;
    logic              word_big_endian;
  } lnde_cfg_t;

  // One classified entry: its bytes in send order, index of the final byte,
  // and the rejection flag.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [BIDX_W-1:0]                last_idx;
    logic                             err;
  } lnde_entry_t;

endpackage

FILE: sv/lnde_front.sv
// ----------------------------------------------------------------------------
// lnde_front
// Accepts line-table entries, forms pc and line deltas against the previous
// entry and packs them into the shortest byte encoding.
// ----------------------------------------------------------------------------
module lnde_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lnde_pkg::lnde_cfg_t         cfg,
  input  logic                        accept,
  input  logic [lnde_pkg::PC_W-1:0]   entry_pc,
  input  logic [lnde_pkg::LINE_W-1:0] entry_line,
  input  logic                        new_table,
  output lnde_pkg::lnde_entry_t       entry
);

  logic [lnde_pkg::PC_W-1:0]    prev_pc_r,   prev_pc_nxt;
  logic [lnde_pkg::LINE_W-1:0]  prev_line_r, prev_line_nxt;
  logic [lnde_pkg::PC_W-1:0]    base_pc;
  logic [lnde_pkg::LINE_W-1:0]  base_line;
  logic [lnde_pkg::DELTA_W-1:0] pd;
  logic signed [lnde_pkg::DELTA_W-1:0] ld;
  logic                         pd_neg;
  logic                         pd_le31, pd_le127;
  logic                         fmt_one, fmt_two, fmt_three;
  logic [15:0]                  word_a, word_b;

  function automatic logic [7:0] word_first(input logic [15:0] w, input logic be);
    return be ? w[15:8] : w[7:0];
  endfunction

  function automatic logic [7:0] word_second(input logic [15:0] w, input logic be);
    return be ? w[7:0] : w[15:8];
  endfunction

  always_comb begin
    base_pc   = new_table ? cfg.initial_pc   : prev_pc_r;
    base_line = new_table ? cfg.initial_line : prev_line_r;
    pd = {1'b0, entry_pc} - {1'b0, base_pc};
    ld = $signed({1'b0, entry_line} - {1'b0, base_line});
    pd_neg   = pd[lnde_pkg::DELTA_W-1];
    pd_le31  = (pd[15:5] == 11'd0);
    pd_le127 = (pd[15:7] == 9'd0);
    fmt_one   = pd_le31 && (ld >= 17'sd0) && (ld <= 17'sd3);
    fmt_two   = pd_le31 && (ld >= -17'sd256) && (ld <= 17'sd255);
    fmt_three = pd_le127 && (ld >= -17'sd8192) && (ld <= 17'sd8191);
  end

  always_comb begin
    entry  = '0;
    word_a = '0;
    word_b = '0;
    if (pd_neg) begin
      entry.err      = 1'b1;
      entry.last_idx = 3'd0;
    end else if (fmt_one) begin
      entry.bytes[0] = {1'b0, pd[4:0], ld[1:0]};
      entry.last_idx = 3'd0;
    end else if (fmt_two) begin
      entry.bytes[0] = {lnde_pkg::TAG_TWO_BYTE, pd[4:0], ld[8]};
      entry.bytes[1] = ld[7:0];
      entry.last_idx = 3'd1;
    end else if (fmt_three) begin
      word_a         = {pd[1:0], ld[13:0]};
      entry.bytes[0] = {lnde_pkg::TAG_THREE_BYTE, pd[6:2]};
      entry.bytes[1] = word_first(word_a, cfg.word_big_endian);
      entry.bytes[2] = word_second(word_a, cfg.word_big_endian);
      entry.last_idx = 3'd2;
    end else begin
      word_a         = pd[15:0];
      word_b         = ld[15:0];
      entry.bytes[0] = ld[lnde_pkg::DELTA_W-1] ? lnde_pkg::TAG_FIVE_NEG
                                               : lnde_pkg::TAG_FIVE_POS;
      entry.bytes[1] = word_first(word_a, cfg.word_big_endian);
      entry.bytes[2] = word_second(word_a, cfg.word_big_endian);
      entry.bytes[3] = word_first(word_b, cfg.word_big_endian);
      entry.bytes[4] = word_second(word_b, cfg.word_big_endian);
      entry.last_idx = 3'd4;
    end
  end

  // Seed on a new table even when the entry itself is rejected.
  always_comb begin
    prev_pc_nxt   = prev_pc_r;
    prev_line_nxt = prev_line_r;
    if (accept) begin
      if (pd_neg) begin
        prev_pc_nxt   = base_pc;
        prev_line_nxt = base_line;
      end else begin
        prev_pc_nxt   = entry_pc;
        prev_line_nxt = entry_line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pc_r   <= '0;
      prev_line_r <= '0;
    end else begin
      prev_pc_r   <= prev_pc_nxt;
      prev_line_r <= prev_line_nxt;
    end
  end

endmodule

FILE: sv/lnde_queue.sv
// ----------------------------------------------------------------------------
// lnde_queue
// Short FIFO of classified entries between the front and the serializer.
// ----------------------------------------------------------------------------
module lnde_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lnde_pkg::lnde_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output lnde_pkg::lnde_entry_t head,
  output logic                  valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lnde_pkg::lnde_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/lnde_back.sv
// ----------------------------------------------------------------------------
// lnde_back
// Serializes classified entries into one byte per request through an output
// register.
// ----------------------------------------------------------------------------
module lnde_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  lnde_pkg::lnde_entry_t       q_head,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [lnde_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_byte,
  output logic                        out_pc_backwards
);

  lnde_pkg::lnde_entry_t           cur_r, cur_nxt;
  logic [lnde_pkg::BIDX_W-1:0]     idx_r, idx_nxt;
  logic                            busy_r, busy_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lnde_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_err_r, out_err_nxt;
  logic                            out_adv, emit, is_last, take;

  assign out_adv = !out_valid_r || out_pop;
  assign emit    = busy_r && out_adv;
  assign is_last = (idx_r == cur_r.last_idx);
  // Load the next entry as the final byte of the current one goes out.
  assign take    = q_valid && (!busy_r || (emit && is_last));
  assign q_pop   = take;

  always_comb begin
    cur_nxt       = take ? q_head : cur_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = emit || (out_valid_r && !out_pop);
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (take) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (emit) begin
      idx_nxt  = idx_r + 1'b1;
      busy_nxt = !is_last;
    end
    if (emit) begin
      out_byte_nxt = cur_r.bytes[idx_r];
      out_last_nxt = is_last;
      out_err_nxt  = cur_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_byte    = out_last_r;
  assign out_pc_backwards = out_err_r;

endmodule

FILE: sv/line_number_delta_encoder.sv
// ----------------------------------------------------------------------------
// line_number_delta_encoder
// Encodes line-table entries as pc/line deltas in 1, 2, 3 or 5 bytes.
// ----------------------------------------------------------------------------
// An entry is accepted whenever in_full is low, one per cycle, and is encoded
// in the cycle it is taken; the queue between the encoder and the serializer
// holds QUEUE_DEPTH encoded entries. Results leave one byte per cycle while
// out_pop is high, through a registered output; an entry has 1 to 5 bytes,
// with 5 for entries that need the long format. On its way out an entry
// passes the queue slot, the serializer's entry register and the output
// register. A rejected entry (pc going backwards) gives one
// byte of zero with out_pc_backwards set. Configuration registers take effect
// on the next accepted entry and should only be written while idle.
module line_number_delta_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lnde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lnde_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [lnde_pkg::PC_W-1:0]       in_entry_pc,
  input  logic [lnde_pkg::LINE_W-1:0]     in_entry_line,
  input  logic                            in_new_table,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [lnde_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_last_byte,
  output logic                            out_pc_backwards
);

  lnde_pkg::lnde_cfg_t   cfg_r, cfg_nxt;
  lnde_pkg::lnde_entry_t fr_entry, q_head;
  logic                  accept, q_full, q_valid, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lnde_pkg::CFG_INITIAL_PC:      cfg_nxt.initial_pc      = cfg_data;
        lnde_pkg::CFG_INITIAL_LINE:    cfg_nxt.initial_line    = cfg_data;
        lnde_pkg::CFG_WORD_BIG_ENDIAN: cfg_nxt.word_big_endian = cfg_data[0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  lnde_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .entry_pc   (in_entry_pc),
    .entry_line (in_entry_line),
    .new_table  (in_new_table),
    .entry      (fr_entry)
  );

  lnde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (fr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  lnde_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_pc_backwards (out_pc_backwards)
  );

endmodule

FILE: sv/lnde_checker.sv
// ----------------------------------------------------------------------------
// lnde_checker
// Port-level checks for the line-number delta encoder, bound to the top.
// ----------------------------------------------------------------------------
module lnde_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [lnde_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last_byte,
  input logic                        out_pc_backwards
);

  // A rejected entry is always a single result.
  a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pc_backwards) |-> out_last_byte)
    else $error("rejected entry result not marked last");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pc_backwards) |-> (out_byte == '0))
    else $error("rejected entry result carries a nonzero byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte)))
    else $error("waiting result dropped or changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("block not empty after reset");

endmodule

bind line_number_delta_encoder lnde_checker u_lnde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_byte         (out_byte),
  .out_last_byte    (out_last_byte),
  .out_pc_backwards (out_pc_backwards)
);
